### rtl/bfsp_pkg.sv
// package: shared types and codes of the shortest path unit
package bfsp_pkg;

  localparam int DIST_W = 49;

  typedef logic [1:0] op_t;
  localparam op_t OP_CLEAR = 2'd0;
  localparam op_t OP_ADD   = 2'd1;
  localparam op_t OP_RUN   = 2'd2;
  localparam op_t OP_NONE  = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_REJECT = 2'd1;
  localparam status_t ST_REPORT = 2'd2;
  localparam status_t ST_NEGCYC = 2'd3;

  typedef struct packed {
    op_t                operation;
    logic [5:0]         edge_from;
    logic [5:0]         edge_to;
    logic signed [31:0] edge_weight;
    logic [5:0]         source_vertex;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [5:0]         vertex;
    logic signed [39:0] distance;
    logic [5:0]         predecessor;
    logic               has_predecessor;
    logic               reachable;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [5:0]         tail;
    logic [5:0]         head;
    logic signed [31:0] weight;
  } edge_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] dist_acc;
    logic [5:0]               pred;
    logic                     has_pred;
  } vert_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_TCHK, S_TWAIT, S_EISSUE, S_ECHK, S_DCHK,
    S_PEND, S_RISSUE, S_ROUT, S_NEG
  } state_t;

endpackage

### rtl/bfsp_ram.sv
// generic single-port-write ram with registered read
module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### rtl/bellman_ford_shortest_paths_unit.sv
// top level: single source shortest path unit over a loaded edge store
//
// input channel in_valid/in_stall/in_data carries one item: clear the edge
// store, add one edge, or run from a source vertex. results leave on
// out_valid/out_stall/out_data through an output register. cfg_we/cfg_wdata
// sets vertex_count; the user must set it only while the unit is idle, the
// block itself does not enforce this. clear, add and rejected items give one
// result in the next cycle; a new item is taken every cycle while the output
// drains. a run checks each tail vertex in turn: for a reached tail it reads
// its distance, then reads every stored edge and relaxes each edge from that
// tail, for each tail in each pass, up to vertex_count passes; it ends early
// after a pass with no change. it then gives one report per vertex, or one
// negative cycle result. the edge store memory and the vertex memory each
// have one read port, so the memory reads of a run follow one after another.
// reset empties the edge store and sets vertex_count to 1. while the
// receiver stalls, the held result stays and the run waits at its next
// report; no item is taken until the run has delivered all results.
module bellman_ford_shortest_paths_unit import bfsp_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [6:0] cfg_wdata
);
  localparam int VA_W = $clog2(MAX_VERTICES);
  localparam int VC_W = $clog2(MAX_VERTICES + 1);
  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EL_W = $clog2(MAX_EDGES + 1);

  state_t state_r, state_nxt;
  logic [6:0] vcount_r;
  logic [EL_W-1:0] edges_loaded_r;
  logic [EL_W-1:0] e_idx_r;
  logic [VC_W-1:0] t_r, pass_r, v_r;
  logic [VA_W-1:0] src_r;
  logic [MAX_VERTICES-1:0] reached_r;
  logic changed_r;
  logic signed [DIST_W-1:0] dist_t_r;
  logic [5:0] head_r;
  logic signed [31:0] w_r;
  logic out_valid_r;
  out_item_t out_data_r;

  logic [VC_W-1:0] n_eff;
  logic out_free, in_acc, load_out;
  out_item_t out_nxt;
  logic e_re;
  edge_t e_rdata;
  logic v_re, v_we;
  logic [VA_W-1:0] v_raddr, v_waddr;
  vert_t v_rdata, v_wdata;
  logic signed [DIST_W-1:0] cand;
  logic better, e_match, add_ok, run_ok;

  assign n_eff = (vcount_r > 7'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES) : VC_W'(vcount_r);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !(state_r == S_IDLE && out_free);
  assign in_acc = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  assign add_ok = (7'(in_data.edge_from) < 7'(n_eff)) && (7'(in_data.edge_to) < 7'(n_eff))
                  && (edges_loaded_r != EL_W'(MAX_EDGES));
  assign run_ok = 7'(in_data.source_vertex) < 7'(n_eff);
  assign e_match = (7'(e_rdata.tail) == 7'(t_r)) && (7'(e_rdata.head) < 7'(n_eff));
  assign cand = dist_t_r + {{(DIST_W-32){w_r[31]}}, w_r};
  assign better = !reached_r[head_r[VA_W-1:0]] || (cand < v_rdata.dist_acc);

  bfsp_ram #(.WIDTH($bits(edge_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk),
    .we(in_acc && in_data.operation == OP_ADD && add_ok),
    .waddr(edges_loaded_r[EA_W-1:0]),
    .wdata({in_data.edge_from, in_data.edge_to, in_data.edge_weight}),
    .re(e_re),
    .raddr(e_idx_r[EA_W-1:0]),
    .rdata(e_rdata)
  );

  bfsp_ram #(.WIDTH($bits(vert_t)), .DEPTH(MAX_VERTICES)) u_vert_ram (
    .clk(clk),
    .we(v_we),
    .waddr(v_waddr),
    .wdata(v_wdata),
    .re(v_re),
    .raddr(v_raddr),
    .rdata(v_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.operation == OP_RUN && run_ok) state_nxt = S_INIT;
      end
      S_INIT: state_nxt = S_TCHK;
      S_TCHK: begin
        if (t_r == n_eff) state_nxt = S_PEND;
        else if (reached_r[t_r[VA_W-1:0]]) state_nxt = S_TWAIT;
      end
      S_TWAIT: state_nxt = S_EISSUE;
      S_EISSUE: state_nxt = (e_idx_r == edges_loaded_r) ? S_TCHK : S_ECHK;
      S_ECHK: state_nxt = e_match ? S_DCHK : S_EISSUE;
      S_DCHK: state_nxt = (better && pass_r == n_eff) ? S_NEG : S_EISSUE;
      S_PEND: state_nxt = changed_r ? S_TCHK : S_RISSUE;
      S_RISSUE: state_nxt = S_ROUT;
      S_ROUT: begin
        if (out_free) state_nxt = (v_r + 1'b1 == n_eff) ? S_IDLE : S_RISSUE;
      end
      S_NEG: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    e_re = 1'b0;
    v_re = 1'b0;
    v_raddr = t_r[VA_W-1:0];
    v_we = 1'b0;
    v_waddr = src_r;
    v_wdata = '0;
    load_out = 1'b0;
    out_nxt = '0;
    out_nxt.last = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data.operation)
            OP_CLEAR: begin
              load_out = 1'b1;
              out_nxt.status = ST_OK;
            end
            OP_ADD: begin
              load_out = 1'b1;
              out_nxt.status = add_ok ? ST_OK : ST_REJECT;
            end
            OP_RUN: begin
              load_out = !run_ok;
              out_nxt.status = ST_REJECT;
            end
            default: begin
              load_out = 1'b1;
              out_nxt.status = ST_REJECT;
            end
          endcase
        end
      end
      S_INIT: v_we = 1'b1;
      S_TCHK: v_re = (t_r != n_eff) && reached_r[t_r[VA_W-1:0]];
      S_EISSUE: e_re = (e_idx_r != edges_loaded_r);
      S_ECHK: begin
        v_re = e_match;
        v_raddr = e_rdata.head[VA_W-1:0];
      end
      S_DCHK: begin
        v_we = better && (pass_r != n_eff);
        v_waddr = head_r[VA_W-1:0];
        v_wdata.dist_acc = cand;
        v_wdata.pred = 6'(t_r);
        v_wdata.has_pred = 1'b1;
      end
      S_RISSUE: begin
        v_re = 1'b1;
        v_raddr = v_r[VA_W-1:0];
      end
      S_ROUT: begin
        load_out = out_free;
        out_nxt.status = ST_REPORT;
        out_nxt.vertex = 6'(v_r);
        out_nxt.last = (v_r + 1'b1 == n_eff);
        if (reached_r[v_r[VA_W-1:0]]) begin
          out_nxt.reachable = 1'b1;
          out_nxt.distance = v_rdata.dist_acc[39:0];
          out_nxt.has_predecessor = v_rdata.has_pred;
          out_nxt.predecessor = v_rdata.has_pred ? v_rdata.pred : 6'd0;
        end
      end
      S_NEG: begin
        load_out = out_free;
        out_nxt.status = ST_NEGCYC;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vcount_r <= 7'd1;
      edges_loaded_r <= '0;
      out_valid_r <= 1'b0;
      reached_r <= '0;
      changed_r <= 1'b0;
      e_idx_r <= '0;
      t_r <= '0;
      pass_r <= '0;
      v_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) vcount_r <= cfg_wdata;
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (in_acc && in_data.operation == OP_CLEAR) edges_loaded_r <= '0;
      if (in_acc && in_data.operation == OP_ADD && add_ok) edges_loaded_r <= edges_loaded_r + 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_data.operation == OP_RUN && run_ok) begin
            reached_r <= '0;
            reached_r[in_data.source_vertex[VA_W-1:0]] <= 1'b1;
          end
        end
        S_INIT: begin
          t_r <= '0;
          pass_r <= VC_W'(1);
          changed_r <= 1'b0;
        end
        S_TCHK: begin
          if (t_r != n_eff && !reached_r[t_r[VA_W-1:0]]) t_r <= t_r + 1'b1;
        end
        S_TWAIT: e_idx_r <= '0;
        S_EISSUE: if (e_idx_r == edges_loaded_r) t_r <= t_r + 1'b1;
        S_ECHK: if (!e_match) e_idx_r <= e_idx_r + 1'b1;
        S_DCHK: begin
          e_idx_r <= e_idx_r + 1'b1;
          if (better && pass_r != n_eff) begin
            reached_r[head_r[VA_W-1:0]] <= 1'b1;
            changed_r <= 1'b1;
          end
        end
        S_PEND: begin
          t_r <= '0;
          v_r <= '0;
          changed_r <= 1'b0;
          pass_r <= pass_r + 1'b1;
        end
        S_ROUT: if (out_free) v_r <= v_r + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_data_r <= out_nxt;
    if (state_r == S_IDLE) src_r <= in_data.source_vertex[VA_W-1:0];
    if (state_r == S_TWAIT) dist_t_r <= v_rdata.dist_acc;
    if (state_r == S_DCHK && better && head_r == 6'(t_r)) dist_t_r <= cand;
    if (state_r == S_ECHK) begin
      head_r <= e_rdata.head;
      w_r <= e_rdata.weight;
    end
  end

  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    v_we |-> !(v_re && v_raddr == v_waddr)) else $error("vertex ram read/write collision");
  a_dchk_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DCHK |-> $past(state_r) == S_ECHK) else $error("relax without edge read");
  a_neg_last_pass: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_NEG |-> pass_r == n_eff) else $error("negative cycle before last pass");
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("item taken during run");
endmodule

### dv/bfsp_path_checker.sv
// checker: predicts shortest path results per item and compares the result channel
module bfsp_path_checker import bfsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  input  logic      cfg_we,
  input  logic [6:0] cfg_wdata,
  output int        fail_count,
  output int        reports_pending
);

  localparam int EDGE_DEPTH = 1024;
  localparam int VERT_DEPTH = 64;

  logic [5:0]  edge_tails [EDGE_DEPTH];
  logic [5:0]  edge_heads [EDGE_DEPTH];
  int          edge_weights [EDGE_DEPTH];
  int unsigned edge_total;
  logic [6:0]  vertex_limit;

  longint      path_dist [VERT_DEPTH];
  logic [5:0]  path_pred [VERT_DEPTH];
  bit          path_has_pred [VERT_DEPTH];
  bit          path_reached [VERT_DEPTH];

  out_item_t   expected_reports [$];

  function automatic void expect_item(out_item_t r);
    expected_reports = {expected_reports, r};
  endfunction

  function automatic out_item_t status_item(status_t st);
    out_item_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // true when the relaxation settles without a negative cycle
  function automatic bit relax_from(int n, int src);
    int     pass;
    int     t;
    int     e;
    int     h;
    bit     changed;
    longint cand;
    for (t = 0; t < VERT_DEPTH; t++) begin
      path_dist[t] = 0;
      path_pred[t] = '0;
      path_has_pred[t] = 0;
      path_reached[t] = 0;
    end
    path_reached[src] = 1;
    for (pass = 1; pass <= n; pass++) begin
      changed = 0;
      for (t = 0; t < n; t++) begin
        if (!path_reached[t]) continue;
        for (e = 0; e < int'(edge_total); e++) begin
          if (int'(edge_tails[e]) != t) continue;
          h = int'(edge_heads[e]);
          if (h >= n) continue;
          cand = path_dist[t] + longint'(edge_weights[e]);
          if (!path_reached[h] || cand < path_dist[h]) begin
            if (pass == n) return 0;
            path_dist[h] = cand;
            path_pred[h] = t[5:0];
            path_has_pred[h] = 1;
            path_reached[h] = 1;
            changed = 1;
          end
        end
      end
      if (!changed) break;
    end
    return 1;
  endfunction

  task automatic predict_item(in_item_t it);
    int        n;
    int        v;
    out_item_t r;
    n = (vertex_limit > 7'd64) ? 64 : int'(vertex_limit);
    case (it.operation)
      OP_CLEAR: begin
        edge_total = 0;
        expect_item(status_item(ST_OK));
      end
      OP_ADD: begin
        if (int'(it.edge_from) >= n || int'(it.edge_to) >= n || edge_total >= EDGE_DEPTH)
          expect_item(status_item(ST_REJECT));
        else begin
          edge_tails[edge_total] = it.edge_from;
          edge_heads[edge_total] = it.edge_to;
          edge_weights[edge_total] = it.edge_weight;
          edge_total++;
          expect_item(status_item(ST_OK));
        end
      end
      OP_RUN: begin
        if (int'(it.source_vertex) >= n)
          expect_item(status_item(ST_REJECT));
        else if (!relax_from(n, int'(it.source_vertex)))
          expect_item(status_item(ST_NEGCYC));
        else begin
          for (v = 0; v < n; v++) begin
            r = '0;
            r.status = ST_REPORT;
            r.vertex = v[5:0];
            r.reachable = path_reached[v];
            if (path_reached[v]) begin
              r.distance = path_dist[v][39:0];
              r.predecessor = path_has_pred[v] ? path_pred[v] : '0;
              r.has_predecessor = path_has_pred[v];
            end
            r.last = (v + 1 == n);
            expect_item(r);
          end
        end
      end
      default: expect_item(status_item(ST_REJECT));
    endcase
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_reports.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: st=%0d v=%0d d=%0d", got.status, got.vertex,
                 got.distance);
      return;
    end
    want = expected_reports.pop_front();
    if (got.status !== want.status || got.vertex !== want.vertex ||
        got.distance !== want.distance || got.predecessor !== want.predecessor ||
        got.has_predecessor !== want.has_predecessor ||
        got.reachable !== want.reachable || got.last !== want.last) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch expected: st=%0d v=%0d d=%0d p=%0d hp=%0b r=%0b l=%0b",
                 want.status, want.vertex, want.distance, want.predecessor,
                 want.has_predecessor, want.reachable, want.last);
        $display("         actual:   st=%0d v=%0d d=%0d p=%0d hp=%0b r=%0b l=%0b",
                 got.status, got.vertex, got.distance, got.predecessor,
                 got.has_predecessor, got.reachable, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      edge_total = 0;
      vertex_limit = 7'd1;
      fail_count = 0;
      expected_reports.delete();
    end else begin
      if (cfg_we) vertex_limit = cfg_wdata;
      if (in_valid && !in_stall) predict_item(in_data);
      if (out_valid && !out_stall) check_result(out_data);
    end
    reports_pending = expected_reports.size();
  end

endmodule

### dv/tb_bellman_ford_shortest_paths_unit.sv
// testbench top: stimulus, idling and verdict for the shortest path unit
module tb_bellman_ford_shortest_paths_unit;
  import bfsp_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int RANDOM_ITEMS = 130;

  logic      clk = 0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_we;
  logic [6:0] cfg_wdata;

  int fail_count;
  int reports_pending;
  int cycle_count = 0;
  int hold_cycles = 0;
  bit quiet = 0;
  int random_sent = 0;

  bellman_ford_shortest_paths_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  bfsp_path_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .reports_pending(reports_pending)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bellman_ford_shortest_paths_unit regression: fail");
      $finish;
    end
  end

  // receiver stall bursts, plus a long hold-off on request
  initial begin
    int  burst;
    bit  burst_stall;
    burst = 0;
    burst_stall = 0;
    out_stall <= 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1;
        hold_cycles--;
      end else if (quiet) begin
        out_stall <= 0;
      end else begin
        if (burst == 0) begin
          burst = $urandom_range(1, 16);
          burst_stall = ($urandom_range(0, 2) == 0);
        end
        out_stall <= burst_stall;
        burst--;
      end
    end
  end

  task automatic send_item(op_t op, logic [5:0] from, logic [5:0] to,
                           logic signed [31:0] w, logic [5:0] src);
    in_item_t it;
    int       gap;
    it.operation = op;
    it.edge_from = from;
    it.edge_to = to;
    it.edge_weight = w;
    it.source_vertex = src;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_vertex_count(logic [6:0] value);
    drain_results();
    cfg_we <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic signed [31:0] pick_weight();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom_range(0, 70) - 20;
    if (sel < 8) return $urandom;
    return sel == 8 ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  task automatic random_phase();
    int n;
    int vc;
    int edges;
    int runs;
    int k;
    if ($urandom_range(0, 11) == 0) vc = $urandom_range(64, 127);
    else if ($urandom_range(0, 9) == 0) vc = $urandom_range(0, 1);
    else vc = $urandom_range(2, 8);
    set_vertex_count(vc[6:0]);
    n = vc > 64 ? 64 : vc;
    if ($urandom_range(0, 4) != 0) begin
      send_item(OP_CLEAR, 6'($urandom), 6'($urandom), $urandom, 6'($urandom));
      random_sent++;
    end
    edges = $urandom_range(0, n > 8 ? 6 : 12);
    for (k = 0; k < edges; k++) begin
      if (n == 0 || $urandom_range(0, 9) == 0)
        send_item(OP_ADD, 6'($urandom), 6'($urandom), pick_weight(), 6'($urandom));
      else
        send_item(OP_ADD, 6'($urandom_range(0, n - 1)), 6'($urandom_range(0, n - 1)),
                  pick_weight(), 6'($urandom));
      random_sent++;
    end
    runs = $urandom_range(1, 4);
    for (k = 0; k < runs; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(OP_NONE, 6'($urandom), 6'($urandom), $urandom, 6'($urandom));
      else if (n == 0 || $urandom_range(0, 7) == 0)
        send_item(OP_RUN, 6'($urandom), 6'($urandom), $urandom, 6'($urandom));
      else
        send_item(OP_RUN, 6'($urandom), 6'($urandom), $urandom,
                  6'($urandom_range(0, n - 1)));
      random_sent++;
    end
  endtask

  initial begin
    int k;
    rst_n <= 0;
    in_valid <= 0;
    in_data <= '0;
    cfg_we <= 0;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // single vertex after reset
    send_item(OP_RUN, 0, 0, 0, 0);
    send_item(OP_RUN, 0, 0, 0, 1);
    send_item(OP_ADD, 0, 0, 5, 0);
    send_item(OP_NONE, 0, 0, 0, 0);

    set_vertex_count(4);
    send_item(OP_CLEAR, 0, 0, 0, 0);
    send_item(OP_ADD, 0, 1, 32'sh8000_0000, 0);
    send_item(OP_ADD, 1, 2, 32'sh7fff_ffff, 0);
    send_item(OP_ADD, 0, 2, 7, 0);
    send_item(OP_ADD, 2, 3, 3, 0);
    send_item(OP_ADD, 4, 0, 1, 0);
    send_item(OP_ADD, 0, 4, 1, 0);
    send_item(OP_RUN, 0, 0, 0, 0);
    send_item(OP_RUN, 0, 0, 0, 3);
    send_item(OP_RUN, 0, 0, 0, 4);
    send_item(OP_ADD, 3, 2, -10, 0);
    send_item(OP_RUN, 0, 0, 0, 0);

    // edges on vertices 2 and 3 go stale
    set_vertex_count(2);
    send_item(OP_RUN, 0, 0, 0, 0);

    set_vertex_count(0);
    send_item(OP_ADD, 0, 0, 1, 0);
    send_item(OP_RUN, 0, 0, 0, 0);

    set_vertex_count(127);
    send_item(OP_CLEAR, 0, 0, 0, 0);
    send_item(OP_ADD, 63, 0, -1, 0);
    send_item(OP_ADD, 0, 63, 1, 0);
    send_item(OP_RUN, 0, 0, 0, 63);
    send_item(OP_RUN, 0, 0, 0, 0);

    // a longer edge list on two vertices
    set_vertex_count(2);
    send_item(OP_CLEAR, 0, 0, 0, 0);
    for (k = 0; k < 60; k++)
      send_item(OP_ADD, 6'($urandom_range(0, 1)), 6'($urandom_range(0, 1)),
                $urandom_range(0, 9), 0);
    send_item(OP_RUN, 0, 0, 0, 1);

    // long receiver hold-off while adds keep coming
    set_vertex_count(4);
    send_item(OP_CLEAR, 0, 0, 0, 0);
    hold_cycles = 300;
    for (k = 0; k < 40; k++)
      send_item(OP_ADD, 6'($urandom_range(0, 3)), 6'($urandom_range(0, 3)),
                pick_weight(), 0);
    send_item(OP_RUN, 0, 0, 0, 0);
    drain_results();

    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent > RANDOM_ITEMS - 40) quiet = 1;
      random_phase();
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && reports_pending == 0)
      $display("bellman_ford_shortest_paths_unit regression: pass");
    else
      $display("bellman_ford_shortest_paths_unit regression: fail");
    $finish;
  end

endmodule
